@@ rtl/core/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHECK_IMPLY(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");
`define CHECK_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");
`else
`define CHECK_IMPLY(lbl, clk, rst, pre, post)
`define CHECK_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

@@ rtl/core/bsc_pkg.sv @@
// types and constants of the barometric compensation datapath
package bsc_pkg;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned RAW_W = 20;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned DIV_CELLS = 32;

   localparam logic [CSR_IDX_W-1:0] REG_CAL_T = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAL_PL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CAL_PM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CAL_PH = 3'd3;

   localparam logic [31:0] FINE_OFS = 32'd64000;
   localparam logic [31:0] P1_OFS = 32'd32768;
   localparam logic [31:0] RAW_FULL = 32'd1048576;
   localparam logic [31:0] P_SCALE = 32'd3125;
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
   localparam logic [31:0] ROUND_T = 32'd128;

   typedef logic [31:0] word_type;

   // one transfer through the divider row
   typedef struct packed {
      word_type rem;
      word_type num;
      word_type quo;
      word_type dvs;
      logic     dbl;
      logic     dz;
      word_type temp;
      word_type fine;
   } div_cell_type;

   function automatic word_type sext16(input logic [15:0] w);
      return {{16{w[15]}}, w};
   endfunction
endpackage

@@ rtl/core/bsc_if.sv @@
// handshake channels of the compensation block
interface bsc_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temperature;
   logic [19:0] raw_pressure;
   modport source (output valid, raw_temperature, raw_pressure, input ready);
   modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bsc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temperature_centi;
   logic signed [31:0] fine_temperature;
   logic [31:0]        pressure_pa;
   logic               divisor_zero;
   modport source (output valid, temperature_centi, fine_temperature, pressure_pa,
                   divisor_zero, input ready);
   modport sink (input valid, temperature_centi, fine_temperature, pressure_pa,
                 divisor_zero, output ready);
endinterface

@@ rtl/core/bsc_front.sv @@
// temperature and pressure stages ahead of the divider row
module bsc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [19:0]           at,
   input  logic [19:0]           ap,
   input  logic [47:0]           cal_t,
   input  logic [63:0]           cal_pl,
   input  logic [63:0]           cal_pm,
   input  logic                  dn_ready,
   output logic                  up_ready,
   output logic                  out_valid,
   output bsc_pkg::div_cell_type out_data
);
   import bsc_pkg::*;

   localparam int unsigned STAGES = 7;

   word_type t1, t2, t3, p1, p2, p3, p4, p5, p6;
   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] en;

   word_type s1_ta_ff, s1_dd_ff, s1_ta_in, s1_dd_in, d;
   word_type s2_a_ff, s2_bb_ff, s2_a_in, s2_bb_in;
   word_type s3_fine_ff, s3_fine_in;
   word_type s4_temp_ff, s4_a_ff, s4_qq_ff, s4_fine_ff;
   word_type s4_temp_in, s4_a_in, s4_qq_in, q;
   word_type s5_temp_ff, s5_fine_ff, s5_b1_ff, s5_ap5_ff, s5_t_ff, s5_u_ff;
   word_type s5_b1_in, s5_ap5_in, s5_t_in, s5_u_in;
   word_type s6_temp_ff, s6_fine_ff, s6_b_ff, s6_m_ff, s6_b_in, s6_m_in, a2;
   word_type s7_temp_ff, s7_fine_ff, s7_dvs_ff, s7_pm_ff, s7_dvs_in, s7_pm_in;
   logic [19:0] ap1_ff, ap2_ff, ap3_ff, ap4_ff, ap5_ff, ap6_ff;

   assign t1 = {16'd0, cal_t[15:0]};
   assign t2 = sext16(cal_t[31:16]);
   assign t3 = sext16(cal_t[47:32]);
   assign p1 = {16'd0, cal_pl[15:0]};
   assign p2 = sext16(cal_pl[31:16]);
   assign p3 = sext16(cal_pl[47:32]);
   assign p4 = sext16(cal_pl[63:48]);
   assign p5 = sext16(cal_pm[15:0]);
   assign p6 = sext16(cal_pm[31:16]);

   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || dn_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign up_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   // temperature
   always_comb begin
      s1_ta_in = (({12'd0, at} >> 3) - (t1 << 1)) * t2;
      d = ({12'd0, at} >> 4) - t1;
      s1_dd_in = d * d;
      s2_a_in = $unsigned($signed(s1_ta_ff) >>> 11);
      s2_bb_in = $unsigned($signed(s1_dd_ff) >>> 12) * t3;
      s3_fine_in = s2_a_ff + $unsigned($signed(s2_bb_ff) >>> 14);
      s4_temp_in = $unsigned($signed((s3_fine_ff << 2) + s3_fine_ff + ROUND_T) >>> 8);
      s4_a_in = $unsigned($signed(s3_fine_ff) >>> 1) - FINE_OFS;
      q = $unsigned($signed(s4_a_in) >>> 2);
      s4_qq_in = q * q;
   end

   // pressure ahead of the division
   always_comb begin
      s5_b1_in = $unsigned($signed(s4_qq_ff) >>> 11) * p6;
      s5_ap5_in = s4_a_ff * p5;
      s5_t_in = p3 * $unsigned($signed(s4_qq_ff) >>> 13);
      s5_u_in = p2 * s4_a_ff;
      s6_b_in = $unsigned($signed(s5_b1_ff + (s5_ap5_ff << 1)) >>> 2) + (p4 << 16);
      a2 = $unsigned($signed($unsigned($signed(s5_t_ff) >>> 3)
                             + $unsigned($signed(s5_u_ff) >>> 1)) >>> 18);
      s6_m_in = (P1_OFS + a2) * p1;
      s7_dvs_in = $unsigned($signed(s6_m_ff) >>> 15);
      s7_pm_in = ((RAW_FULL - {12'd0, ap6_ff}) - $unsigned($signed(s6_b_ff) >>> 12))
                 * P_SCALE;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ta_ff <= s1_ta_in;
         s1_dd_ff <= s1_dd_in;
         ap1_ff <= ap;
      end
      if (en[1]) begin
         s2_a_ff <= s2_a_in;
         s2_bb_ff <= s2_bb_in;
         ap2_ff <= ap1_ff;
      end
      if (en[2]) begin
         s3_fine_ff <= s3_fine_in;
         ap3_ff <= ap2_ff;
      end
      if (en[3]) begin
         s4_temp_ff <= s4_temp_in;
         s4_fine_ff <= s3_fine_ff;
         s4_a_ff <= s4_a_in;
         s4_qq_ff <= s4_qq_in;
         ap4_ff <= ap3_ff;
      end
      if (en[4]) begin
         s5_temp_ff <= s4_temp_ff;
         s5_fine_ff <= s4_fine_ff;
         s5_b1_ff <= s5_b1_in;
         s5_ap5_ff <= s5_ap5_in;
         s5_t_ff <= s5_t_in;
         s5_u_ff <= s5_u_in;
         ap5_ff <= ap4_ff;
      end
      if (en[5]) begin
         s6_temp_ff <= s5_temp_ff;
         s6_fine_ff <= s5_fine_ff;
         s6_b_ff <= s6_b_in;
         s6_m_ff <= s6_m_in;
         ap6_ff <= ap5_ff;
      end
      if (en[6]) begin
         s7_temp_ff <= s6_temp_ff;
         s7_fine_ff <= s6_fine_ff;
         s7_dvs_ff <= s7_dvs_in;
         s7_pm_ff <= s7_pm_in;
      end
   end

   // numerator doubled up front unless its top bit is set
   always_comb begin
      out_valid = v_ff[STAGES-1];
      out_data.rem = '0;
      out_data.quo = '0;
      out_data.dvs = s7_dvs_ff;
      out_data.dbl = s7_pm_ff >= SIGN_BIT;
      out_data.num = (s7_pm_ff >= SIGN_BIT) ? s7_pm_ff : (s7_pm_ff << 1);
      out_data.dz = s7_dvs_ff == '0;
      out_data.temp = s7_temp_ff;
      out_data.fine = s7_fine_ff;
   end
endmodule

@@ rtl/core/bsc_div_cell.sv @@
// one restoring division cell, one quotient bit per transfer
module bsc_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  bsc_pkg::div_cell_type in_data,
   input  logic                  dn_ready,
   output logic                  up_ready,
   output logic                  out_valid,
   output bsc_pkg::div_cell_type out_data
);
   import bsc_pkg::*;

   logic         v_ff;
   div_cell_type d_ff, d_in;
   logic [32:0]  trial;
   logic         fits;

   assign up_ready = !v_ff || dn_ready;

   always_comb begin
      trial = {in_data.rem, in_data.num[31]};
      fits = trial >= {1'b0, in_data.dvs};
      d_in = in_data;
      d_in.rem = fits ? 32'(trial - {1'b0, in_data.dvs}) : trial[31:0];
      d_in.num = in_data.num << 1;
      d_in.quo = {in_data.quo[30:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (up_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data = d_ff;
endmodule

@@ rtl/core/bsc_back.sv @@
// pressure correction after the division and the result register
module bsc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  bsc_pkg::div_cell_type in_data,
   input  logic [63:0]           cal_pm,
   input  logic [15:0]           cal_ph,
   input  logic                  dn_ready,
   output logic                  up_ready,
   output logic                  out_valid,
   output logic [31:0]           out_temp,
   output logic [31:0]           out_fine,
   output logic [31:0]           out_press,
   output logic                  out_dz
);
   import bsc_pkg::*;

   localparam int unsigned STAGES = 3;

   word_type p7, p8, p9;
   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] en;

   word_type b1_p_ff, b1_sq_ff, b1_pb_ff, b1_temp_ff, b1_fine_ff;
   word_type b1_p_in, b1_sq_in, b1_pb_in;
   logic     b1_dz_ff, b2_dz_ff, b3_dz_ff;
   word_type b2_p_ff, b2_x_ff, b2_bq_ff, b2_temp_ff, b2_fine_ff, b2_x_in, b2_bq_in;
   word_type b3_p_ff, b3_temp_ff, b3_fine_ff, b3_p_in;

   assign p7 = sext16(cal_pm[47:32]);
   assign p8 = sext16(cal_pm[63:48]);
   assign p9 = sext16(cal_ph);

   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || dn_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign up_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   always_comb begin
      b1_p_in = in_data.dbl ? {in_data.quo[30:0], 1'b0} : in_data.quo;
      b1_sq_in = (b1_p_in >> 3) * (b1_p_in >> 3);
      b1_pb_in = (b1_p_in >> 2) * p8;
      b2_x_in = p9 * (b1_sq_ff >> 13);
      b2_bq_in = $unsigned($signed(b1_pb_ff) >>> 13);
      b3_p_in = b2_dz_ff ? '0 :
                b2_p_ff + $unsigned($signed($unsigned($signed(b2_x_ff) >>> 12)
                                            + b2_bq_ff + p7) >>> 4);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         b1_p_ff <= b1_p_in;
         b1_sq_ff <= b1_sq_in;
         b1_pb_ff <= b1_pb_in;
         b1_dz_ff <= in_data.dz;
         b1_temp_ff <= in_data.temp;
         b1_fine_ff <= in_data.fine;
      end
      if (en[1]) begin
         b2_p_ff <= b1_p_ff;
         b2_x_ff <= b2_x_in;
         b2_bq_ff <= b2_bq_in;
         b2_dz_ff <= b1_dz_ff;
         b2_temp_ff <= b1_temp_ff;
         b2_fine_ff <= b1_fine_ff;
      end
      if (en[2]) begin
         b3_p_ff <= b3_p_in;
         b3_dz_ff <= b2_dz_ff;
         b3_temp_ff <= b2_temp_ff;
         b3_fine_ff <= b2_fine_ff;
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_temp = b3_temp_ff;
   assign out_fine = b3_fine_ff;
   assign out_press = b3_p_ff;
   assign out_dz = b3_dz_ff;
endmodule

@@ rtl/core/barometric_sensor_compensation.sv @@
// top level: calibration registers, front stages, divider row, back stages
//
// channel   direction  transfer when        payload
// req_bus   in         valid && ready       raw_temperature, raw_pressure
// rsp_bus   out        valid && ready       temperature_centi, fine_temperature,
//                                           pressure_pa, divisor_zero
// csr_*     in         csr_we               csr_index, csr_wdata
//
// one item per cycle sustained while the receiver takes results; 7 front stages,
// one cell per quotient bit in the 32-cell divider row, 3 back stages.
// each stage moves when it is empty or the next one moves, so bubbles close up
// and a held result stops items entering only once every stage is full.
// synchronous reset clears stage valid bits and calibration registers.
module barometric_sensor_compensation (
   input  logic                            clock,
   input  logic                            reset,
   bsc_req_if.sink                         req_bus,
   bsc_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bsc_pkg::*;
   `include "assert_macros.svh"

   logic [47:0] cal_t_ff;
   logic [63:0] cal_pl_ff, cal_pm_ff;
   logic [15:0] cal_ph_ff;

   logic         front_valid, front_ready;
   div_cell_type front_data;
   logic         cv [DIV_CELLS+1];
   logic         cr [DIV_CELLS+1];
   div_cell_type cd [DIV_CELLS+1];
   logic [31:0]  o_temp, o_fine;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t_ff <= '0;
         cal_pl_ff <= '0;
         cal_pm_ff <= '0;
         cal_ph_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_CAL_T: begin
               cal_t_ff <= csr_wdata[47:0];
            end
            REG_CAL_PL: begin
               cal_pl_ff <= csr_wdata;
            end
            REG_CAL_PM: begin
               cal_pm_ff <= csr_wdata;
            end
            REG_CAL_PH: begin
               cal_ph_ff <= csr_wdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   bsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .at       (req_bus.raw_temperature),
      .ap       (req_bus.raw_pressure),
      .cal_t    (cal_t_ff),
      .cal_pl   (cal_pl_ff),
      .cal_pm   (cal_pm_ff),
      .dn_ready (cr[0]),
      .up_ready (front_ready),
      .out_valid(front_valid),
      .out_data (front_data)
   );
   assign req_bus.ready = front_ready;
   assign cv[0] = front_valid;
   assign cd[0] = front_data;

   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
      bsc_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (cv[i]),
         .in_data  (cd[i]),
         .dn_ready (cr[i+1]),
         .up_ready (cr[i]),
         .out_valid(cv[i+1]),
         .out_data (cd[i+1])
      );
   end

   bsc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (cv[DIV_CELLS]),
      .in_data  (cd[DIV_CELLS]),
      .cal_pm   (cal_pm_ff),
      .cal_ph   (cal_ph_ff),
      .dn_ready (rsp_bus.ready),
      .up_ready (cr[DIV_CELLS]),
      .out_valid(rsp_bus.valid),
      .out_temp (o_temp),
      .out_fine (o_fine),
      .out_press(rsp_bus.pressure_pa),
      .out_dz   (rsp_bus.divisor_zero)
   );
   assign rsp_bus.temperature_centi = $signed(o_temp);
   assign rsp_bus.fine_temperature = $signed(o_fine);

   `CHECK_IMPLY(a_dz_zero, clock, reset, rsp_bus.valid && rsp_bus.divisor_zero, rsp_bus.pressure_pa == '0)
   `CHECK_IMPLY(a_full_stall, clock, reset, !req_bus.ready, rsp_bus.valid && !rsp_bus.ready)
   `CHECK_NEXT(a_bad_index, clock, reset, csr_we && (csr_index > REG_CAL_PH), $stable(cal_t_ff) && $stable(cal_pl_ff) && $stable(cal_pm_ff) && $stable(cal_ph_ff))
endmodule

@@ tb/tb_barometric_sensor_compensation.sv @@
// self-checking testbench of the barometric compensation block
module tb_barometric_sensor_compensation;
   timeunit 1ns;
   timeprecision 1ps;

   import bsc_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned DRAIN_CYCLES = 60;
   localparam int unsigned HOLD_CYCLES = 300;

   typedef struct packed {
      logic [RAW_W-1:0] raw_t;
      logic [RAW_W-1:0] raw_p;
   } sample_type;

   typedef struct packed {
      word_type temp;
      word_type fine;
      word_type pres;
      logic     dz;
   } reading_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bsc_req_if req ();
   bsc_rsp_if rsp ();

   barometric_sensor_compensation dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req),
      .rsp_bus   (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // calibration as the block should hold it
   logic [47:0] cal_t;
   logic [63:0] cal_pl;
   logic [63:0] cal_pm;
   logic [15:0] cal_ph;

   sample_type  pending_samples[$];
   reading_type expected_readings[$];

   int unsigned errors = 0;
   int unsigned n_accepted = 0;
   int unsigned n_popped = 0;
   int unsigned n_results = 0;
   int unsigned n_zero_div = 0;
   int unsigned idle_cycles = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   bit calm = 0;
   // whether the last offered item was just taken
   bit last_fire = 0;

   function automatic word_type sra(input word_type x, input int n);
      return word_type'($signed(x) >>> n);
   endfunction

   function automatic word_type sx(input logic [15:0] w);
      return {{16{w[15]}}, w};
   endfunction

   function automatic reading_type compensate_reading(input sample_type s);
      word_type at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      word_type a, b, d, q, fine, p;
      reading_type r;
      at = {12'b0, s.raw_t};
      ap = {12'b0, s.raw_p};
      t1 = {16'b0, cal_t[15:0]};
      t2 = sx(cal_t[31:16]);
      t3 = sx(cal_t[47:32]);
      p1 = {16'b0, cal_pl[15:0]};
      p2 = sx(cal_pl[31:16]);
      p3 = sx(cal_pl[47:32]);
      p4 = sx(cal_pl[63:48]);
      p5 = sx(cal_pm[15:0]);
      p6 = sx(cal_pm[31:16]);
      p7 = sx(cal_pm[47:32]);
      p8 = sx(cal_pm[63:48]);
      p9 = sx(cal_ph);

      a = sra(((at >> 3) - (t1 << 1)) * t2, 11);
      d = (at >> 4) - t1;
      b = sra(sra(d * d, 12) * t3, 14);
      fine = a + b;
      r.temp = sra(fine * 32'd5 + ROUND_T, 8);
      r.fine = fine;

      a = sra(fine, 1) - FINE_OFS;
      q = sra(a, 2);
      b = sra(q * q, 11) * p6;
      b = b + ((a * p5) << 1);
      b = sra(b, 2) + (p4 << 16);
      a = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * a, 1), 18);
      a = sra((P1_OFS + a) * p1, 15);

      if (a == 32'd0) begin
         r.pres = '0;
         r.dz = 1'b1;
      end else begin
         p = (RAW_FULL - ap) - sra(b, 12);
         p = p * P_SCALE;
         // unsigned divide, doubled before or after depending on headroom
         if (p < SIGN_BIT) p = (p << 1) / a;
         else p = (p / a) * 32'd2;
         a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
         b = sra((p >> 2) * p8, 13);
         r.pres = p + sra(a + b + p7, 4);
         r.dz = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input word_type got,
                                  input word_type want);
      errors++;
      $display("mismatch on result %0d: %s got %h expected %h", n_results, field, got, want);
   endtask

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      req.valid = 0;
      req.raw_temperature = '0;
      req.raw_pressure = '0;
      rsp.ready = 0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
   end

   // request side: accept tracking and expectation
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         expected_readings.push_back(compensate_reading({req.raw_temperature,
                                                         req.raw_pressure}));
         n_accepted++;
      end
   end

   // result side: compare against oldest expectation
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         n_results++;
         if (expected_readings.size() == 0) begin
            errors++;
            $display("unexpected result %0d with nothing pending", n_results);
         end else begin
            want = expected_readings.pop_front();
            if (rsp.temperature_centi !== want.temp)
               report_mismatch("temperature_centi", rsp.temperature_centi, want.temp);
            if (rsp.fine_temperature !== want.fine)
               report_mismatch("fine_temperature", rsp.fine_temperature, want.fine);
            if (rsp.pressure_pa !== want.pres)
               report_mismatch("pressure_pa", rsp.pressure_pa, want.pres);
            if (rsp.divisor_zero !== want.dz)
               report_mismatch("divisor_zero", {31'b0, rsp.divisor_zero}, {31'b0, want.dz});
            if (want.dz) n_zero_div++;
         end
      end
   end

   // driver: valid stays up until the transfer happens
   always @(negedge clock) begin
      if (!reset) begin
         if (n_accepted != n_popped) begin
            void'(pending_samples.pop_front());
            n_popped++;
         end
         if (pending_samples.size() > 0 &&
             ((req.valid && n_accepted == n_popped && !last_fire) ||
              calm || $urandom_range(99) >= 27)) begin
            req.valid <= 1'b1;
            req.raw_temperature <= pending_samples[0].raw_t;
            req.raw_pressure <= pending_samples[0].raw_p;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) last_fire <= !reset && req.valid && req.ready;

   // receiver with random stalls and one long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= calm || $urandom_range(99) >= 27;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_barometric_sensor_compensation: done, errors");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 0;
      case (idx)
         REG_CAL_T: cal_t = data[47:0];
         REG_CAL_PL: cal_pl = data;
         REG_CAL_PM: cal_pm = data;
         REG_CAL_PH: cal_ph = data[15:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_samples.size() > 0 || req.valid || expected_readings.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_sample(input logic [19:0] t, input logic [19:0] p);
      sample_type s;
      s.raw_t = t;
      s.raw_p = p;
      pending_samples.push_back(s);
   endtask

   task automatic run_phase(input logic [63:0] t, input logic [63:0] pl,
                            input logic [63:0] pm, input logic [63:0] ph,
                            input int n_random, input bit long_hold);
      write_csr(REG_CAL_T, t);
      write_csr(REG_CAL_PL, pl);
      write_csr(REG_CAL_PM, pm);
      write_csr(REG_CAL_PH, ph);
      add_sample(20'h00000, 20'h00000);
      add_sample(20'hFFFFF, 20'hFFFFF);
      add_sample(20'h00000, 20'hFFFFF);
      add_sample(20'hFFFFF, 20'h00000);
      add_sample(20'h80000, 20'h80000);
      add_sample(20'h7FFFF, 20'h7FFFF);
      add_sample(20'hAAAAA, 20'h55555);
      add_sample(20'h55555, 20'hAAAAA);
      add_sample(20'd519888, 20'd415148);
      add_sample(20'h00001, 20'h00001);
      add_sample(20'd400000, 20'd300000);
      add_sample(20'd600000, 20'd500000);
      for (int i = 0; i < n_random; i++)
         add_sample(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)));
      if (long_hold) hold_requests++;
      wait_drained();
   endtask

   initial begin
      cal_t = '0;
      cal_pl = '0;
      cal_pm = '0;
      cal_ph = '0;
      reset = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // all-zero calibration: divisor is zero everywhere
      run_phase('0, '0, '0, '0, 30, 0);
      // unknown index must be ignored
      write_csr(3'd5, {$urandom, $urandom});
      // typical calibration, with the long receiver hold-off
      run_phase(64'h0000_FC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D,
                64'hC6F8_3C8C_FFF9_008C, 64'h1770, 300, 1);
      calm = 1;
      run_phase(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 40, 0);
      calm = 0;
      run_phase(64'h1234_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
                64'h7FFF_7FFF_7FFF_7FFF, 64'h5A5A_7FFF, 40, 0);
      run_phase(64'h0000_8000_8000_0000, 64'h8000_8000_8000_0000,
                64'h8000_8000_8000_8000, 64'h8000, 40, 0);
      for (int k = 0; k < 3; k++)
         run_phase({$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, 40, 0);

      $display("covered %0d samples over 8 calibration sets, %0d results checked",
               n_accepted, n_results);
      $display("%0d results with zero divisor, %0d mismatches", n_zero_div, errors);
      if (errors == 0 && expected_readings.size() == 0)
         $display("tb_barometric_sensor_compensation: done, clean");
      else
         $display("tb_barometric_sensor_compensation: done, errors");
      $finish;
   end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/bsc_pkg.sv
rtl/core/bsc_if.sv
rtl/core/bsc_front.sv
rtl/core/bsc_div_cell.sv
rtl/core/bsc_back.sv
rtl/core/barometric_sensor_compensation.sv
tb/tb_barometric_sensor_compensation.sv
